// File: design/ilc_pkg.sv
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared types, character codes and result codes of the INI line classifier.
// ----------------------------------------------------------------------------
package ilc_pkg;

	localparam int unsigned ILC_MAX_LINE = 1023;
	localparam int unsigned COUNT_W      = 10;
	localparam int unsigned SEC_W        = 16;
	localparam int unsigned QUEUE_DEPTH  = 2;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_OPEN   = 8'h5B;
	localparam logic [7:0] CH_CLOSE  = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	localparam logic [2:0] KIND_KEY     = 3'd0;
	localparam logic [2:0] KIND_VALUE   = 3'd1;
	localparam logic [2:0] KIND_SECTION = 3'd2;
	localparam logic [2:0] KIND_COMMENT = 3'd3;
	localparam logic [2:0] KIND_LINE    = 3'd4;

	localparam logic [2:0] CLS_EMPTY   = 3'd0;
	localparam logic [2:0] CLS_COMMENT = 3'd1;
	localparam logic [2:0] CLS_KEY     = 3'd2;
	localparam logic [2:0] CLS_SECTION = 3'd3;
	localparam logic [2:0] CLS_ERROR   = 3'd4;

	localparam logic [1:0] QUOTE_NONE   = 2'd0;
	localparam logic [1:0] QUOTE_SINGLE = 2'd1;
	localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

	typedef enum logic [3:0] {
		PH_LEAD      = 4'd0,
		PH_COMMENT   = 4'd1,
		PH_KEY       = 4'd2,
		PH_AFTER_KEY = 4'd3,
		PH_AFTER_EQ  = 4'd4,
		PH_VALUE     = 4'd5,
		PH_SEC_NAME  = 4'd6,
		PH_SEC_DONE  = 4'd7,
		PH_ERROR     = 4'd8
	} phase_t;

	typedef struct packed {
		logic blank;
		logic space;
		logic alnum;
		logic key_char;
		logic comment_start;
		logic open_br;
		logic close_br;
		logic equals;
		logic nul;
	} char_flags_t;

	typedef struct packed {
		logic [7:0]  char_code;
		logic        end_of_line;
		char_flags_t flags;
	} queue_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: design/ilc_char_if.sv
// ----------------------------------------------------------------------------
// ilc_char_if
// Character channel: one text byte or one end-of-line mark per transfer.
// ----------------------------------------------------------------------------
interface ilc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_line;

	modport source (output valid, output char_code, output end_of_line, input ready);
	modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

// File: design/ilc_result_if.sv
// ----------------------------------------------------------------------------
// ilc_result_if
// Result channel: tagged text characters and line results.
// ----------------------------------------------------------------------------
interface ilc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  item_kind;
	logic [7:0]  text_char;
	logic [2:0]  line_class;
	logic [1:0]  quote_kind;
	logic [9:0]  key_length;
	logic [9:0]  value_length;
	logic        line_discarded;
	logic [15:0] section_number;

	modport source (
		output valid, output item_kind, output text_char, output line_class,
		output quote_kind, output key_length, output value_length,
		output line_discarded, output section_number, input ready
	);
	modport sink (
		input valid, input item_kind, input text_char, input line_class,
		input quote_kind, input key_length, input value_length,
		input line_discarded, input section_number, output ready
	);
endinterface

// File: design/ini_line_classifier.sv
// ----------------------------------------------------------------------------
// ini_line_classifier
// Path: an accepted character is written into the queue, and its result is
// registered in the back end output register; a stalled sink adds its stall.
// Throughput: one item per cycle while the result sink is not stalling.
// A two-entry queue parts the decode front from the state machine back end.
// Reset (arst_n low) clears the queue, line state and section count at once.
// ----------------------------------------------------------------------------
module ini_line_classifier #(
	parameter int unsigned MAX_LINE = ilc_pkg::ILC_MAX_LINE
) (
	input  logic         clk,
	input  logic         arst_n,
	ilc_char_if.sink     chars,
	ilc_result_if.source results
);
	import ilc_pkg::*;

	// front to queue
	logic          push;
	queue_entry_t  push_entry;
	queue_status_t q_stat;

	// queue to back end
	logic          q_valid;
	logic          q_pop;
	queue_entry_t  q_entry;

	// Decode each byte's class as it arrives; hold off the source when full.
	ilc_front u_front (
		.chars      (chars),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Absorb short stalls of the result side without stopping the front.
	ilc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry),
		.q_stat     (q_stat)
	);

	// Advance the line phase, tag characters and register the result.
	ilc_back #(
		.MAX_LINE (MAX_LINE)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.results (results)
	);

`ifndef SYNTHESIS
	// an accepted transfer must land in the queue
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.ready) |=> !q_stat.empty)
		else $error("accepted character did not reach the queue");

	// a discarded line only ever opens the first, unnamed section
	a_discard_first: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.item_kind == KIND_LINE && results.line_discarded)
		|-> (results.section_number == 16'd1))
		else $error("discarded line with section number other than one");
`endif
endmodule

// File: design/ilc_front.sv
// ----------------------------------------------------------------------------
// ilc_front
// Accepts characters, decodes their character class and pushes them on.
// ----------------------------------------------------------------------------
module ilc_front (
	ilc_char_if.sink              chars,
	input  ilc_pkg::queue_status_t q_stat,
	output logic                  push,
	output ilc_pkg::queue_entry_t push_entry
);
	import ilc_pkg::*;

	logic [7:0]  c;
	char_flags_t fl;

	assign c = chars.char_code;

	always_comb begin
		fl.space         = (c == CH_SPACE);
		fl.blank         = fl.space || (c >= CH_TAB && c <= CH_CR);
		fl.alnum         = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		                   (c >= 8'h61 && c <= 8'h7A);
		fl.key_char      = fl.alnum || (c == CH_UNDER) || (c == CH_DOT);
		fl.comment_start = (c == CH_SEMI) || (c == CH_HASH);
		fl.open_br       = (c == CH_OPEN);
		fl.close_br      = (c == CH_CLOSE);
		fl.equals        = (c == CH_EQUALS);
		fl.nul           = (c == CH_NUL);
	end

	assign chars.ready            = !q_stat.full;
	assign push                   = chars.valid && !q_stat.full;
	assign push_entry.char_code   = c;
	assign push_entry.end_of_line = chars.end_of_line;
	assign push_entry.flags       = fl;
endmodule

// File: design/ilc_queue.sv
// ----------------------------------------------------------------------------
// ilc_queue
// Short FIFO between the decode front and the line state back end.
// ----------------------------------------------------------------------------
module ilc_queue #(
	parameter int unsigned DEPTH = ilc_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ilc_pkg::queue_entry_t push_entry,
	input  logic                  pop,
	output logic                  pop_valid,
	output ilc_pkg::queue_entry_t pop_entry,
	output ilc_pkg::queue_status_t q_stat
);
	import ilc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	queue_entry_t     entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign do_pop       = pop && (count_q != '0);
	assign pop_valid    = (count_q != '0);
	assign pop_entry    = entries_q[rd_ptr_q];
	assign q_stat.full  = (count_q == FULL);
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// File: design/ilc_back.sv
// ----------------------------------------------------------------------------
// ilc_back
// Line state machine: tags characters, classifies lines, holds the result.
// ----------------------------------------------------------------------------
module ilc_back #(
	parameter int unsigned MAX_LINE = ilc_pkg::ILC_MAX_LINE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  ilc_pkg::queue_entry_t q_entry,
	output logic                  q_pop,
	ilc_result_if.source          results
);
	import ilc_pkg::*;

	localparam int unsigned CAP_MAX = (1 << COUNT_W) - 1;
	localparam int unsigned CAP_INT = (MAX_LINE < CAP_MAX) ? MAX_LINE : CAP_MAX;
	localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_INT);
	localparam logic [SEC_W-1:0]   SEC_MAX   = '1;

	phase_t             phase_q, phase_d;
	logic [7:0]         first_q, first_d;
	logic [7:0]         last_q, last_d;
	logic [COUNT_W-1:0] key_q, key_d;
	logic [COUNT_W-1:0] val_q, val_d;
	logic [COUNT_W-1:0] sec_name_q, sec_name_d;
	logic               term_q, term_d;
	logic               have_sec_q, have_sec_d;
	logic [SEC_W-1:0]   sections_q, sections_d;

	logic               fire;
	logic               emit;
	logic [2:0]         kind;
	logic [2:0]         cls;
	logic [1:0]         quote;
	logic               discarded;
	logic               opens;
	char_flags_t        fl;
	logic [7:0]         c;

	logic               out_valid_q;
	logic [2:0]         kind_q;
	logic [7:0]         char_q;
	logic [2:0]         cls_q;
	logic [1:0]         quote_q;
	logic [COUNT_W-1:0] key_len_q;
	logic [COUNT_W-1:0] val_len_q;
	logic               disc_q;
	logic [SEC_W-1:0]   secnum_q;

	assign fl    = q_entry.flags;
	assign c     = q_entry.char_code;
	assign fire  = q_valid && (!out_valid_q || results.ready);
	assign q_pop = fire;

	// line classification from the phase reached at line end
	always_comb begin
		unique case (phase_q)
			PH_LEAD:                cls = CLS_EMPTY;
			PH_COMMENT:             cls = CLS_COMMENT;
			PH_AFTER_EQ, PH_VALUE:  cls = CLS_KEY;
			PH_SEC_DONE:            cls = CLS_SECTION;
			default:                cls = CLS_ERROR;
		endcase
		quote = QUOTE_NONE;
		if (cls == CLS_KEY && val_q > COUNT_W'(1) && last_q == first_q) begin
			if (first_q == CH_DQUOTE) begin
				quote = QUOTE_DOUBLE;
			end else if (first_q == CH_SQUOTE) begin
				quote = QUOTE_SINGLE;
			end
		end
		opens     = (cls == CLS_SECTION) || !have_sec_q;
		discarded = (cls != CLS_SECTION) && !have_sec_q;
	end

	// output decision
	always_comb begin
		emit = 1'b0;
		kind = KIND_LINE;
		if (q_entry.end_of_line) begin
			emit = 1'b1;
		end else if (!term_q && !fl.nul) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (!fl.blank && fl.comment_start) begin
						emit = 1'b1;
						kind = KIND_COMMENT;
					end else if (!fl.blank && fl.key_char) begin
						emit = 1'b1;
						kind = KIND_KEY;
					end
				end
				PH_COMMENT: begin
					emit = 1'b1;
					kind = KIND_COMMENT;
				end
				PH_KEY: begin
					emit = fl.key_char;
					kind = KIND_KEY;
				end
				PH_AFTER_EQ: begin
					emit = !fl.blank;
					kind = KIND_VALUE;
				end
				PH_VALUE: begin
					emit = 1'b1;
					kind = KIND_VALUE;
				end
				PH_SEC_NAME: begin
					emit = fl.alnum || fl.space;
					kind = KIND_SECTION;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// next line state
	always_comb begin
		phase_d    = phase_q;
		first_d    = first_q;
		last_d     = last_q;
		key_d      = key_q;
		val_d      = val_q;
		sec_name_d = sec_name_q;
		term_d     = term_q;
		have_sec_d = have_sec_q;
		sections_d = sections_q;
		if (q_entry.end_of_line) begin
			phase_d    = PH_LEAD;
			first_d    = '0;
			last_d     = '0;
			key_d      = '0;
			val_d      = '0;
			sec_name_d = '0;
			term_d     = 1'b0;
			if (opens) begin
				have_sec_d = 1'b1;
				if (sections_q != SEC_MAX) begin
					sections_d = sections_q + 1'b1;
				end
			end
		end else if (term_q) begin
			term_d = 1'b1;
		end else if (fl.nul) begin
			term_d = 1'b1;
		end else begin
			unique case (phase_q)
				PH_LEAD: begin
					if (fl.blank) begin
						phase_d = PH_LEAD;
					end else if (fl.comment_start) begin
						phase_d = PH_COMMENT;
					end else if (fl.open_br) begin
						phase_d = PH_SEC_NAME;
					end else if (fl.key_char) begin
						phase_d = PH_KEY;
						key_d   = (key_q < COUNT_CAP) ? key_q + 1'b1 : key_q;
					end else begin
						phase_d = PH_ERROR;
					end
				end
				PH_COMMENT: begin
					phase_d = PH_COMMENT;
				end
				PH_KEY: begin
					if (fl.key_char) begin
						key_d = (key_q < COUNT_CAP) ? key_q + 1'b1 : key_q;
					end else if (fl.blank) begin
						phase_d = PH_AFTER_KEY;
					end else if (fl.equals) begin
						phase_d = PH_AFTER_EQ;
					end else begin
						phase_d = PH_ERROR;
					end
				end
				PH_AFTER_KEY: begin
					if (!fl.blank) begin
						phase_d = fl.equals ? PH_AFTER_EQ : PH_ERROR;
					end
				end
				PH_AFTER_EQ: begin
					if (!fl.blank) begin
						phase_d = PH_VALUE;
						first_d = c;
						last_d  = c;
						val_d   = COUNT_W'(1);
					end
				end
				PH_VALUE: begin
					last_d = c;
					val_d  = (val_q < COUNT_CAP) ? val_q + 1'b1 : val_q;
				end
				PH_SEC_NAME: begin
					if (fl.alnum || fl.space) begin
						sec_name_d = (sec_name_q < COUNT_CAP) ? sec_name_q + 1'b1 : sec_name_q;
					end else if (fl.close_br && sec_name_q != '0) begin
						phase_d = PH_SEC_DONE;
					end else begin
						phase_d = PH_ERROR;
					end
				end
				PH_SEC_DONE: begin
					phase_d = PH_SEC_DONE;
				end
				default: begin
					phase_d = PH_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			first_q     <= '0;
			last_q      <= '0;
			key_q       <= '0;
			val_q       <= '0;
			sec_name_q  <= '0;
			term_q      <= 1'b0;
			have_sec_q  <= 1'b0;
			sections_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q    <= phase_d;
				first_q    <= first_d;
				last_q     <= last_d;
				key_q      <= key_d;
				val_q      <= val_d;
				sec_name_q <= sec_name_d;
				term_q     <= term_d;
				have_sec_q <= have_sec_d;
				sections_q <= sections_d;
			end
			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q <= kind;
			if (q_entry.end_of_line) begin
				char_q    <= '0;
				cls_q     <= cls;
				quote_q   <= quote;
				key_len_q <= (cls == CLS_KEY) ? key_q : '0;
				val_len_q <= (cls == CLS_KEY) ? val_q : '0;
				disc_q    <= discarded;
				secnum_q  <= sections_d;
			end else begin
				char_q    <= c;
				cls_q     <= CLS_EMPTY;
				quote_q   <= QUOTE_NONE;
				key_len_q <= '0;
				val_len_q <= '0;
				disc_q    <= 1'b0;
				secnum_q  <= '0;
			end
		end
	end

	assign results.valid          = out_valid_q;
	assign results.item_kind      = kind_q;
	assign results.text_char      = char_q;
	assign results.line_class     = cls_q;
	assign results.quote_kind     = quote_q;
	assign results.key_length     = key_len_q;
	assign results.value_length   = val_len_q;
	assign results.line_discarded = disc_q;
	assign results.section_number = secnum_q;
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ini_line_classifier. Lines of INI text go in one
// byte per transfer, each closed by an end-of-line transfer. A predictor in
// the bench tags the characters and classifies every line. Each result
// transfer is checked field by field against the oldest waiting prediction.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ilc_pkg::*;

	// Saturation point of the key, value and section name counters.
	localparam int unsigned COUNT_CAP = (ILC_MAX_LINE < 1023) ? ILC_MAX_LINE : 1023;
	// Cycles without a single transfer on either channel before giving up.
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// Settling time after the last result.
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_CHARS = 720;
	localparam int unsigned MAX_REPORTS  = 100;

	localparam string KEY_CHARS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_.";
	localparam string NAME_CHARS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 ";

	// One tagged character or one line report, as the result channel shows it.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [2:0]  cls;
		logic [1:0]  quote;
		logic [9:0]  key_len;
		logic [9:0]  val_len;
		logic        discarded;
		logic [15:0] sec_num;
	} line_item_t;

	logic clk = 1'b0;
	logic arst_n;

	ilc_char_if   chars_if ();
	ilc_result_if results_if ();

	ini_line_classifier DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// Tags and line reports predicted but not yet seen on the result channel.
	line_item_t classified[$];
	// Text of the line being assembled before it is sent.
	logic [7:0] line_buf[$];

	int unsigned mismatches = 0;
	int unsigned chars_sent = 0;
	bit          src_gaps    = 1'b1;
	bit          sink_stalls = 1'b1;

	// Line state of the predictor.
	phase_t      ln_phase;
	logic [7:0]  first_val;
	logic [7:0]  last_val;
	logic [9:0]  key_cnt;
	logic [9:0]  val_cnt;
	logic [9:0]  name_cnt;
	bit          nul_seen;
	// File state of the predictor: survives line ends.
	bit          in_section;
	logic [15:0] sec_count;

	// ------------------------------------------------------------------------
	// Character classes
	// ------------------------------------------------------------------------
	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_alnum(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_key_char(input logic [7:0] c);
		return is_alnum(c) || c == CH_UNDER || c == CH_DOT;
	endfunction

	function automatic logic [9:0] sat_inc(input logic [9:0] v);
		return (v < COUNT_CAP) ? v + 10'd1 : v;
	endfunction

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	task automatic clear_line_state();
		ln_phase  = PH_LEAD;
		first_val = '0;
		last_val  = '0;
		key_cnt   = '0;
		val_cnt   = '0;
		name_cnt  = '0;
		nul_seen  = 1'b0;
	endtask

	// Advance the line state by one accepted transfer and queue what it yields.
	task automatic classify_item(input logic [7:0] c, input logic eol);
		line_item_t r;
		bit         emit;
		r    = '0;
		emit = 1'b0;
		if (eol) begin
			case (ln_phase)
				PH_LEAD:              r.cls = CLS_EMPTY;
				PH_COMMENT:           r.cls = CLS_COMMENT;
				PH_AFTER_EQ, PH_VALUE: r.cls = CLS_KEY;
				PH_SEC_DONE:          r.cls = CLS_SECTION;
				default:              r.cls = CLS_ERROR;
			endcase
			r.kind = KIND_LINE;
			if (r.cls == CLS_KEY) begin
				r.key_len = key_cnt;
				r.val_len = val_cnt;
				if (val_cnt > 1 && (first_val == CH_SQUOTE || first_val == CH_DQUOTE) &&
				    last_val == first_val)
					r.quote = (first_val == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
			end
			// A header opens a section; so does any line before the first one.
			if (r.cls == CLS_SECTION || !in_section) begin
				r.discarded = (r.cls != CLS_SECTION);
				in_section  = 1'b1;
				if (sec_count != 16'hFFFF)
					sec_count++;
			end
			r.sec_num = sec_count;
			clear_line_state();
			emit = 1'b1;
		end else if (!nul_seen) begin
			if (c == CH_NUL) begin
				nul_seen = 1'b1;
			end else begin
				case (ln_phase)
					PH_LEAD: begin
						if (c == CH_SEMI || c == CH_HASH) begin
							ln_phase = PH_COMMENT;
							r.kind   = KIND_COMMENT;
							emit     = 1'b1;
						end else if (c == CH_OPEN) begin
							ln_phase = PH_SEC_NAME;
						end else if (is_key_char(c)) begin
							ln_phase = PH_KEY;
							key_cnt  = sat_inc(key_cnt);
							r.kind   = KIND_KEY;
							emit     = 1'b1;
						end else if (!is_blank(c)) begin
							ln_phase = PH_ERROR;
						end
					end
					PH_COMMENT: begin
						r.kind = KIND_COMMENT;
						emit   = 1'b1;
					end
					PH_KEY: begin
						if (is_key_char(c)) begin
							key_cnt = sat_inc(key_cnt);
							r.kind  = KIND_KEY;
							emit    = 1'b1;
						end else if (is_blank(c)) begin
							ln_phase = PH_AFTER_KEY;
						end else if (c == CH_EQUALS) begin
							ln_phase = PH_AFTER_EQ;
						end else begin
							ln_phase = PH_ERROR;
						end
					end
					PH_AFTER_KEY: begin
						if (!is_blank(c))
							ln_phase = (c == CH_EQUALS) ? PH_AFTER_EQ : PH_ERROR;
					end
					PH_AFTER_EQ: begin
						if (!is_blank(c)) begin
							ln_phase  = PH_VALUE;
							first_val = c;
							last_val  = c;
							val_cnt   = 10'd1;
							r.kind    = KIND_VALUE;
							emit      = 1'b1;
						end
					end
					PH_VALUE: begin
						last_val = c;
						val_cnt  = sat_inc(val_cnt);
						r.kind   = KIND_VALUE;
						emit     = 1'b1;
					end
					PH_SEC_NAME: begin
						if (is_alnum(c) || c == CH_SPACE) begin
							name_cnt = sat_inc(name_cnt);
							r.kind   = KIND_SECTION;
							emit     = 1'b1;
						end else if (c == CH_CLOSE && name_cnt != 0) begin
							ln_phase = PH_SEC_DONE;
						end else begin
							ln_phase = PH_ERROR;
						end
					end
					PH_SEC_DONE: ;
					default: ln_phase = PH_ERROR;
				endcase
			end
			r.ch = c;
		end
		if (emit)
			classified.push_back(r);
	endtask

	// ------------------------------------------------------------------------
	// Line assembly and the character channel
	// ------------------------------------------------------------------------
	function automatic logic [7:0] rand_key_char();
		return KEY_CHARS[$urandom_range(KEY_CHARS.len() - 1)];
	endfunction

	function automatic logic [7:0] rand_name_char();
		return NAME_CHARS[$urandom_range(NAME_CHARS.len() - 1)];
	endfunction

	// Any byte but NUL, so the line text is not cut short.
	function automatic logic [7:0] rand_text_byte();
		return 8'($urandom_range(255, 1));
	endfunction

	task automatic put_byte(input logic [7:0] b);
		line_buf.push_back(b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	// Append blanks drawn from space, tab, LF, VT, FF and CR.
	task automatic put_blanks(input int unsigned n);
		int unsigned k;
		repeat (n) begin
			k = $urandom_range(5);
			line_buf.push_back((k == 5) ? CH_SPACE : CH_TAB + 8'(k));
		end
	endtask

	// Offer one transfer, with a random gap first when gaps are enabled. Valid
	// stays high on return so that back-to-back transfers need no second
	// assignment in the same step.
	task automatic send_item(input logic [7:0] code, input logic eol);
		while (src_gaps && $urandom_range(99) < 10) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid       <= 1'b1;
		chars_if.char_code   <= code;
		chars_if.end_of_line <= eol;
		@(posedge clk);
		while (chars_if.ready !== 1'b1)
			@(posedge clk);
		classify_item(code, eol);
		chars_sent++;
	endtask

	// Send the assembled line and close it; the byte beside the end-of-line
	// mark is ignored by the block, so make it random.
	task automatic flush_line();
		foreach (line_buf[i])
			send_item(line_buf[i], 1'b0);
		send_item(8'($urandom_range(255)), 1'b1);
		line_buf.delete();
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// One line for each line class, quote rule, error path and NUL cut-off.
	task automatic test_directed_lines();
		// An empty first line opens the unnamed section and is dropped.
		flush_line();
		put_blanks(0);
		for (int b = CH_TAB; b <= CH_CR; b++)
			put_byte(8'(b));
		put_byte(CH_SPACE);
		flush_line();
		put_str("  ; note = x ");
		flush_line();
		put_byte(CH_HASH); put_byte(8'hFF); put_byte(8'h80); put_byte(8'h7F);
		flush_line();
		// Anything after the closing bracket is ignored.
		put_str(" [Main 2]trail=;");
		flush_line();
		put_str("key_1.A = 'quoted'");
		flush_line();
		put_str("k2=\"dq\"");
		flush_line();
		put_str("k3 = '");
		flush_line();
		put_str("k4=\"\"");
		flush_line();
		put_str("k5=");
		flush_line();
		put_str("k6 =  tail  ");
		flush_line();
		put_str("k7 = 'mixed\"");
		flush_line();
		put_str("Z9=");
		put_byte(8'hFF); put_byte(8'h01); put_byte(8'hAA);
		flush_line();
		// Error lines: characters rejected in several phases, and unfinished lines.
		put_str("lonely");
		flush_line();
		put_str("a b=c");
		flush_line();
		put_str("a!=1 more");
		flush_line();
		put_str("[]");
		flush_line();
		put_str("[ab");
		flush_line();
		put_str("[a-b]");
		flush_line();
		put_str("=v");
		flush_line();
		put_str("]");
		flush_line();
		// NUL cuts the line text short.
		put_str("x=1");
		put_byte(CH_NUL);
		put_str("=zz'");
		flush_line();
		put_byte(CH_NUL);
		put_str("abc");
		flush_line();
	endtask

	// Build one random line: mostly well-formed lines with random content,
	// the rest noise, corrupted lines and lines cut short by NUL.
	task automatic build_random_line();
		int unsigned pick;
		int unsigned n;
		logic [7:0]  q;
		pick = $urandom_range(99);
		if ($urandom_range(3) == 0)
			put_blanks($urandom_range(3, 1));
		if (pick < 42) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
			repeat (n) put_byte(rand_key_char());
			if ($urandom_range(1))
				put_blanks($urandom_range(2, 1));
			put_byte(CH_EQUALS);
			if ($urandom_range(1))
				put_blanks($urandom_range(2, 1));
			case ($urandom_range(3))
				0: ;
				1, 2: begin
					q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
					put_byte(q);
					repeat ($urandom_range(8)) put_byte(rand_text_byte());
					// Now and then close with the other quote.
					if ($urandom_range(7) == 0)
						put_byte((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
					else if ($urandom_range(7) != 0)
						put_byte(q);
				end
				default: repeat ($urandom_range(10, 1)) put_byte(rand_text_byte());
			endcase
		end else if (pick < 58) begin
			put_byte(CH_OPEN);
			repeat ($urandom_range(8, 1)) put_byte(rand_name_char());
			put_byte(CH_CLOSE);
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(5, 1)) put_byte(rand_text_byte());
		end else if (pick < 70) begin
			put_byte($urandom_range(1) ? CH_SEMI : CH_HASH);
			repeat ($urandom_range(10)) put_byte(rand_text_byte());
		end else if (pick < 78) begin
			put_blanks($urandom_range(3));
		end else begin
			repeat ($urandom_range(10, 1)) put_byte(8'($urandom_range(255)));
		end
		// Corrupt one byte of some lines.
		if (line_buf.size() != 0 && $urandom_range(99) < 10)
			line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
		// Cut some lines short with a NUL, followed by junk.
		if ($urandom_range(99) < 6) begin
			line_buf.insert($urandom_range(line_buf.size()), CH_NUL);
			repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)));
		end
	endtask

	// Random lines, with a stretch in the middle where neither side idles.
	task automatic test_random_lines();
		int unsigned start;
		start = chars_sent;
		while (chars_sent - start < RANDOM_CHARS) begin
			src_gaps    = !(chars_sent - start >= 300 && chars_sent - start < 550);
			sink_stalls = src_gaps;
			build_random_line();
			flush_line();
		end
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Result checking and sink back-pressure
	// ------------------------------------------------------------------------
	task automatic report_field(input string name, input logic [15:0] want,
	                            input logic [15:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
	endtask

	// Compare each result transfer with the oldest prediction, then pick the
	// next value of ready: high, or low with a one-in-ten chance when stalling.
	always @(posedge clk) begin : result_check
		line_item_t want;
		if (arst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			if (classified.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t ns: unexpected result, expected none, actual kind %0h char %0h",
					         $time, results_if.item_kind, results_if.text_char);
			end else begin
				want = classified.pop_front();
				if (results_if.item_kind !== want.kind)
					report_field("item_kind", want.kind, results_if.item_kind);
				if (results_if.text_char !== want.ch)
					report_field("text_char", want.ch, results_if.text_char);
				if (results_if.line_class !== want.cls)
					report_field("line_class", want.cls, results_if.line_class);
				if (results_if.quote_kind !== want.quote)
					report_field("quote_kind", want.quote, results_if.quote_kind);
				if (results_if.key_length !== want.key_len)
					report_field("key_length", want.key_len, results_if.key_length);
				if (results_if.value_length !== want.val_len)
					report_field("value_length", want.val_len, results_if.value_length);
				if (results_if.line_discarded !== want.discarded)
					report_field("line_discarded", want.discarded, results_if.line_discarded);
				if (results_if.section_number !== want.sec_num)
					report_field("section_number", want.sec_num, results_if.section_number);
			end
		end
		results_if.ready <= !(sink_stalls && $urandom_range(99) < 10);
	end

	// ------------------------------------------------------------------------
	// Watchdog: drop the run once no transfer has happened for too long.
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((chars_if.valid === 1'b1 && chars_if.ready === 1'b1) ||
			    (results_if.valid === 1'b1 && results_if.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		// Hold every input at a known value from time zero.
		arst_n               = 1'b0;
		chars_if.valid       = 1'b0;
		chars_if.char_code   = '0;
		chars_if.end_of_line = 1'b0;
		results_if.ready     = 1'b0;
		clear_line_state();
		in_section = 1'b0;
		sec_count  = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_lines();
		test_random_lines();
		chars_if.valid <= 1'b0;

		// Drain: wait for the last prediction, then give stray results a chance
		// to show. The watchdog covers a block that never delivers.
		while (classified.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && classified.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
